>>> src/crse_pkg.sv
`timescale 1ns / 1ps
// Shared constants, types and command codes of the Catmull-Rom segment evaluator.
package crse_pkg;

  localparam int DIMS    = 4;
  localparam int DIM_W   = (DIMS > 1) ? $clog2(DIMS) : 1;
  localparam int SEL_W   = 4;
  localparam int CMD_W   = 2;
  localparam int SLOT_W  = 2;
  localparam int COORD_W = 16;
  localparam int T_W     = 16;
  localparam int OUT_W   = 24;
  localparam int COEF_W  = 23;
  localparam int CD_W    = 18;
  localparam int OPD_W   = 40;
  localparam int PROD_W  = OPD_W + T_W + 1;
  localparam int ACC_W   = 58;
  localparam int RND_SH  = 25;
  localparam int Y_W     = ACC_W - RND_SH;

  localparam logic [CMD_W-1:0] CMD_LOAD  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_POS   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_DERIV = 2'd2;

  localparam logic [DIM_W-1:0]  LAST_DIM  = DIM_W'(DIMS - 1);
  localparam logic [SEL_W:0]    DIMS_SEL  = (SEL_W + 1)'(DIMS);

  typedef enum logic [1:0] {
    STEP_AB,
    STEP_C,
    STEP_D
  } step_t;

  typedef struct packed {
    logic             load;
    logic             capture;
    logic             coef;
    logic             mul;
    step_t            step;
    logic             fin;
    logic [DIM_W-1:0] dim;
  } dp_cmd_t;

endpackage

>>> src/crse_dp.sv
`timescale 1ns / 1ps
// Datapath: control point store, coefficient stage, shared Horner multiplier, output rounding.
module crse_dp (
  input  logic                                clk,
  input  logic                                rst_n,
  input  crse_pkg::dp_cmd_t                   cmd,
  input  logic [crse_pkg::CMD_W-1:0]          in_command,
  input  logic [crse_pkg::SLOT_W-1:0]         in_point_slot,
  input  logic [crse_pkg::SEL_W-1:0]          in_dim_select,
  input  logic signed [crse_pkg::COORD_W-1:0] in_coord_value,
  input  logic [crse_pkg::T_W-1:0]            in_param_t,
  output logic signed [crse_pkg::OUT_W-1:0]   out_curve_value
);

  logic signed [crse_pkg::COORD_W-1:0] pts_r [crse_pkg::DIMS][4];
  logic [crse_pkg::T_W-1:0]            t_r;
  logic                                deriv_r;
  logic signed [crse_pkg::COEF_W-1:0]  coef_a_r, coef_b_r;
  logic signed [crse_pkg::CD_W-1:0]    coef_c_r, coef_d_r;
  logic signed [crse_pkg::ACC_W-1:0]   acc_r;
  logic signed [crse_pkg::OUT_W-1:0]   out_value_r;

  logic signed [crse_pkg::COEF_W-1:0]  p_w, s_w, e_w, n_w, a2, b2;
  logic signed [crse_pkg::COEF_W-1:0]  a_nxt, b_nxt;
  logic signed [crse_pkg::OPD_W-1:0]   opd;
  logic signed [crse_pkg::ACC_W-1:0]   addend, acc_sh, acc_nxt, rnd;
  logic signed [crse_pkg::PROD_W-1:0]  prod;
  logic signed [crse_pkg::Y_W-1:0]     y;
  logic signed [crse_pkg::OUT_W-1:0]   out_nxt;
  logic                                sel_ok;

  assign sel_ok = {1'b0, in_dim_select} < crse_pkg::DIMS_SEL;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int d = 0; d < crse_pkg::DIMS; d++) begin
        for (int k = 0; k < 4; k++) begin
          pts_r[d][k] <= '0;
        end
      end
    end else if (cmd.load && sel_ok) begin
      pts_r[in_dim_select[crse_pkg::DIM_W-1:0]][in_point_slot] <= in_coord_value;
    end
  end

  always_comb begin
    p_w = crse_pkg::COEF_W'(pts_r[cmd.dim][0]);
    s_w = crse_pkg::COEF_W'(pts_r[cmd.dim][1]);
    e_w = crse_pkg::COEF_W'(pts_r[cmd.dim][2]);
    n_w = crse_pkg::COEF_W'(pts_r[cmd.dim][3]);
    a2 = n_w - p_w + (s_w <<< 1) + s_w - (e_w <<< 1) - e_w;
    b2 = (p_w <<< 1) - (s_w <<< 2) - s_w + (e_w <<< 2) - n_w;
    a_nxt = deriv_r ? (a2 <<< 1) + a2 : a2;
    b_nxt = deriv_r ? (b2 <<< 1) : b2;
  end

  always_comb begin
    acc_sh = acc_r >>> 16;
    unique case (cmd.step)
      crse_pkg::STEP_AB: begin
        opd    = crse_pkg::OPD_W'(coef_a_r);
        addend = crse_pkg::ACC_W'(coef_b_r) <<< 16;
      end
      crse_pkg::STEP_C: begin
        opd    = acc_r[crse_pkg::OPD_W-1:0];
        addend = crse_pkg::ACC_W'(coef_c_r) <<< 32;
      end
      crse_pkg::STEP_D: begin
        opd    = acc_sh[crse_pkg::OPD_W-1:0];
        addend = crse_pkg::ACC_W'(coef_d_r) <<< 32;
      end
      default: begin
        opd    = '0;
        addend = '0;
      end
    endcase
    prod    = opd * $signed({1'b0, t_r});
    acc_nxt = crse_pkg::ACC_W'(prod) + addend;
  end

  always_comb begin
    rnd = acc_r + (crse_pkg::ACC_W'(1) <<< 24);
    y   = rnd[crse_pkg::ACC_W-1:crse_pkg::RND_SH];
    if (y[crse_pkg::Y_W-1:crse_pkg::OUT_W-1] == '0 ||
        y[crse_pkg::Y_W-1:crse_pkg::OUT_W-1] == '1) begin
      out_nxt = y[crse_pkg::OUT_W-1:0];
    end else if (y[crse_pkg::Y_W-1]) begin
      out_nxt = {1'b1, {(crse_pkg::OUT_W-1){1'b0}}};
    end else begin
      out_nxt = {1'b0, {(crse_pkg::OUT_W-1){1'b1}}};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      t_r     <= in_param_t;
      deriv_r <= (in_command == crse_pkg::CMD_DERIV);
    end
    if (cmd.coef) begin
      coef_a_r <= a_nxt;
      coef_b_r <= b_nxt;
      coef_c_r <= crse_pkg::CD_W'(e_w - p_w);
      coef_d_r <= crse_pkg::CD_W'(s_w <<< 1);
    end
    if (cmd.mul) begin
      acc_r <= acc_nxt;
    end
    if (cmd.fin) begin
      out_value_r <= out_nxt;
    end
  end

  assign out_curve_value = out_value_r;

endmodule

>>> src/crse_ctrl.sv
`timescale 1ns / 1ps
// Controller: sequences coefficient, Horner and output steps for each dimension.
module crse_ctrl (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  input  logic [crse_pkg::CMD_W-1:0]      in_command,
  output logic                            busy,
  output crse_pkg::dp_cmd_t               cmd,
  output logic                            out_valid,
  output logic [crse_pkg::DIM_W-1:0]      out_dim,
  output logic                            out_last
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_COEF,
    ST_STEP0,
    ST_STEP1,
    ST_STEP2,
    ST_FIN
  } state_t;

  state_t                       state_r;
  logic [crse_pkg::DIM_W-1:0]   dim_r;
  logic                         deriv_r;
  logic                         valid_r;
  logic [crse_pkg::DIM_W-1:0]   out_dim_r;
  logic                         last_r;
  logic                         accept, eval;

  assign busy   = (state_r != ST_IDLE);
  assign accept = start && !busy;
  assign eval   = (in_command == crse_pkg::CMD_POS) || (in_command == crse_pkg::CMD_DERIV);

  always_comb begin
    cmd         = '0;
    cmd.dim     = dim_r;
    cmd.load    = accept && (in_command == crse_pkg::CMD_LOAD);
    cmd.capture = accept && eval;
    cmd.coef    = (state_r == ST_COEF);
    cmd.fin     = (state_r == ST_FIN);
    unique case (state_r)
      ST_STEP0: begin
        cmd.mul  = 1'b1;
        cmd.step = crse_pkg::STEP_AB;
      end
      ST_STEP1: begin
        cmd.mul  = 1'b1;
        cmd.step = crse_pkg::STEP_C;
      end
      ST_STEP2: begin
        cmd.mul  = 1'b1;
        cmd.step = crse_pkg::STEP_D;
      end
      default: begin
        cmd.mul  = 1'b0;
        cmd.step = crse_pkg::STEP_AB;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      dim_r     <= '0;
      deriv_r   <= 1'b0;
      valid_r   <= 1'b0;
      out_dim_r <= '0;
      last_r    <= 1'b0;
    end else begin
      valid_r   <= (state_r == ST_FIN);
      out_dim_r <= dim_r;
      last_r    <= (state_r == ST_FIN) && (dim_r == crse_pkg::LAST_DIM);
      unique case (state_r)
        ST_IDLE: begin
          if (accept && eval) begin
            state_r <= ST_COEF;
            dim_r   <= '0;
            deriv_r <= (in_command == crse_pkg::CMD_DERIV);
          end
        end
        ST_COEF:  state_r <= ST_STEP0;
        ST_STEP0: state_r <= ST_STEP1;
        ST_STEP1: state_r <= deriv_r ? ST_FIN : ST_STEP2;
        ST_STEP2: state_r <= ST_FIN;
        ST_FIN: begin
          if (dim_r == crse_pkg::LAST_DIM) begin
            state_r <= ST_IDLE;
          end else begin
            state_r <= ST_COEF;
            dim_r   <= dim_r + 1'b1;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_valid = valid_r;
  assign out_dim   = out_dim_r;
  assign out_last  = last_r;

  a_valid_after_fin: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r |-> $past(state_r == ST_FIN))
    else $error("result strobe without a finishing step");

  a_last_ends_item: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FIN && dim_r == crse_pkg::LAST_DIM) |=> (state_r == ST_IDLE))
    else $error("item did not end after the final dimension");

  a_eval_starts_dim0: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && eval) |=> (state_r == ST_COEF && dim_r == '0))
    else $error("evaluate transaction did not start at dimension zero");

  a_last_has_valid: assert property (@(posedge clk) disable iff (!rst_n)
    last_r |-> (valid_r && out_dim_r == crse_pkg::LAST_DIM))
    else $error("last flag outside the final result");

  a_load_no_busy: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> !busy)
    else $error("load transaction started an evaluation");

endmodule

>>> src/catmull_rom_segment_evaluator_unit.sv
`timescale 1ns / 1ps
// Top level of the Catmull-Rom segment evaluator.
// A transaction is taken at a rising edge with start high and busy low.
// in_command selects: load one control coordinate (in_point_slot, in_dim_select,
// in_coord_value), evaluate the position, or evaluate the derivative at in_param_t.
// A load completes in the accepting cycle and gives no result; busy stays low.
// Command code 3 and loads to a dimension beyond the stored set are dropped.
// An evaluation gives one result per dimension, lowest first, each on the out_
// ports for one cycle with out_valid high; out_last_dim marks the final one.
// Each dimension is worked by the single shared multiplier stepping through the
// Horner chain: coefficients, three multiply-add steps for position or two for
// the derivative, then rounding, where the result is registered with its strobe.
// An evaluation holds busy until its final dimension is rounded, so the next
// transaction is taken only after that.
// Reset clears all control points to zero and returns the controller to idle.
// The receiver cannot stall: each result must be taken in its strobe cycle.
module catmull_rom_segment_evaluator_unit (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic [crse_pkg::CMD_W-1:0]          in_command,
  input  logic [crse_pkg::SLOT_W-1:0]         in_point_slot,
  input  logic [crse_pkg::SEL_W-1:0]          in_dim_select,
  input  logic signed [crse_pkg::COORD_W-1:0] in_coord_value,
  input  logic [crse_pkg::T_W-1:0]            in_param_t,
  output logic                                out_valid,
  output logic [crse_pkg::SEL_W-1:0]          out_dim_index,
  output logic signed [crse_pkg::OUT_W-1:0]   out_curve_value,
  output logic                                out_last_dim
);

  crse_pkg::dp_cmd_t            cmd;
  logic [crse_pkg::DIM_W-1:0]   out_dim;

  crse_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .in_command (in_command),
    .busy       (busy),
    .cmd        (cmd),
    .out_valid  (out_valid),
    .out_dim    (out_dim),
    .out_last   (out_last_dim)
  );

  crse_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .in_command      (in_command),
    .in_point_slot   (in_point_slot),
    .in_dim_select   (in_dim_select),
    .in_coord_value  (in_coord_value),
    .in_param_t      (in_param_t),
    .out_curve_value (out_curve_value)
  );

  assign out_dim_index = crse_pkg::SEL_W'(out_dim);

endmodule
